### hw/rtl/sorted_list_insert_delete_search_macros.svh
// Assertion macros used by the sorted key table controller.
`ifndef SORTED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SLIDS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SLIDS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SLIDS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SLIDS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/slids_pkg.sv
// Types and constants shared by the sorted key table modules.
package slids_pkg;

    localparam int SLIDS_CAPACITY = 16;
    localparam int KEY_W          = 32;
    localparam int CNT_OUT_W      = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action                   action;
        logic signed [KEY_W-1:0]   key;
    } t_req_s;

    typedef struct packed {
        t_status                   status;
        logic                      found;
        logic [CNT_OUT_W-1:0]      removed_count;
        logic [CNT_OUT_W-1:0]      entry_count;
        logic signed [KEY_W-1:0]   item_value;
        logic                      last;
    } t_rsp_s;

    // controller -> datapath
    typedef struct packed {
        logic    use_in_key;   // compare against the request key, else the held key
        logic    load_key;
        logic    ins;
        logic    del_step;     // remove one matching entry
        logic    clr_removed;
        logic    out_load;
        t_status out_status;
        logic    out_found;
        logic    out_removed;
        logic    out_item;
        logic    out_last;
    } t_dp_cmd_s;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic any_match;
        logic list_last;
    } t_dp_sts_s;

endpackage

### hw/rtl/slids_dp.sv
// Datapath: sorted key cells, count, held key, removed counter, response register.
module slids_dp
    import slids_pkg::*;
#(
    parameter int CAPACITY = SLIDS_CAPACITY
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [KEY_W-1:0]               i_key,
    input  t_dp_cmd_s                             i_cmd,
    input  logic [$clog2(CAPACITY)-1:0]           i_list_idx,
    output t_dp_sts_s                             o_sts,
    output t_rsp_s                                o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] r_entries [CAPACITY];
    logic signed [KEY_W-1:0] n_entries [CAPACITY];
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_removed, n_removed;
    t_rsp_s                  r_rsp;

    logic signed [KEY_W-1:0] cmp_key;
    logic [CAPACITY-1:0]     valid_c, le_c, ge_c, eq_c;

    assign cmp_key = i_cmd.use_in_key ? i_key : r_key;

    // per-cell compares, all in parallel
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid_c[i] = CW'(i) < r_count;
            le_c[i]    = valid_c[i] && (r_entries[i] <= cmp_key);
            ge_c[i]    = valid_c[i] && (r_entries[i] >= cmp_key);
            eq_c[i]    = valid_c[i] && (r_entries[i] == cmp_key);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
        end
        if (i_cmd.ins) begin
            // cells after the last entry <= key move up one, key lands in the gap
            n_entries[0] = le_c[0] ? r_entries[0] : cmp_key;
            for (int i = 1; i < CAPACITY; i++) begin
                n_entries[i] = le_c[i] ? r_entries[i]
                             : (le_c[i-1] ? cmp_key : r_entries[i-1]);
            end
        end else if (i_cmd.del_step) begin
            // equal keys sit at the bottom of the >= key suffix: pull it down one
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_entries[i] = ge_c[i] ? r_entries[i+1] : r_entries[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.del_step) begin
            n_count = r_count - CW'(1);
        end
        n_removed = r_removed;
        if (i_cmd.clr_removed) begin
            n_removed = '0;
        end else if (i_cmd.del_step) begin
            n_removed = r_removed + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_removed <= '0;
        end else begin
            r_count   <= n_count;
            r_removed <= n_removed;
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.load_key) begin
            r_key <= i_key;
        end
        if (i_cmd.out_load) begin
            r_rsp.status        <= i_cmd.out_status;
            r_rsp.found         <= i_cmd.out_found & (|eq_c);
            r_rsp.removed_count <= i_cmd.out_removed ? CNT_OUT_W'(n_removed) : '0;
            r_rsp.entry_count   <= CNT_OUT_W'(n_count);
            r_rsp.item_value    <= i_cmd.out_item ? r_entries[i_list_idx] : '0;
            r_rsp.last          <= i_cmd.out_last;
        end
    end

    assign o_sts.full      = (r_count == CW'(CAPACITY));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.any_match = |eq_c;
    assign o_sts.list_last = (r_count == (CW'(i_list_idx) + CW'(1)));
    assign o_rsp           = r_rsp;

endmodule

### hw/rtl/slids_ctrl.sv
// Controller: request decode, delete and list sequencing, response valid.
`include "sorted_list_insert_delete_search_macros.svh"

module slids_ctrl
    import slids_pkg::*;
#(
    parameter int CAPACITY = SLIDS_CAPACITY
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    input  t_action                               i_action,
    output logic                                  o_req_ready,
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_ready,
    input  t_dp_sts_s                             i_sts,
    output t_dp_cmd_s                             o_cmd,
    output logic [$clog2(CAPACITY)-1:0]           o_list_idx
);

    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEL  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_rsp_valid, n_rsp_valid;
    t_dp_cmd_s     cmd;
    logic          out_free;
    logic          acc;

    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && out_free;
    assign acc         = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.use_in_key = 1'b1;
                if (acc) begin
                    if (i_action != ACT_INSERT && i_sts.empty) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STAT_EMPTY;
                        cmd.out_last   = 1'b1;
                    end else begin
                        unique case (i_action)
                            ACT_INSERT: begin
                                cmd.ins        = !i_sts.full;
                                cmd.out_load   = 1'b1;
                                cmd.out_status = i_sts.full ? STAT_FULL : STAT_OK;
                                cmd.out_last   = 1'b1;
                            end
                            ACT_DELETE: begin
                                cmd.load_key    = 1'b1;
                                cmd.clr_removed = 1'b1;
                                n_state         = S_DEL;
                            end
                            ACT_SEARCH: begin
                                cmd.out_load  = 1'b1;
                                cmd.out_found = 1'b1;
                                cmd.out_last  = 1'b1;
                            end
                            ACT_LIST: begin
                                n_idx   = '0;
                                n_state = S_LIST;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_DEL: begin
                if (i_sts.any_match) begin
                    cmd.del_step = 1'b1;
                end else if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_removed = 1'b1;
                    cmd.out_last    = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_item = 1'b1;
                    cmd.out_last = i_sts.list_last;
                    n_idx        = r_idx + IW'(1);
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp_valid = cmd.out_load ? 1'b1 : (i_rsp_ready ? 1'b0 : r_rsp_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_list_idx  = r_idx;
    assign o_rsp_valid = r_rsp_valid;

    `SLIDS_ASSERT_IMPL(a_load_into_free, i_clk, i_rst_n, cmd.out_load, out_free)
    `SLIDS_ASSERT_IMPL(a_list_not_empty, i_clk, i_rst_n, r_state == S_LIST, !i_sts.empty)
    `SLIDS_ASSERT_NEXT(a_del_done_idle, i_clk, i_rst_n, r_state == S_DEL && !i_sts.any_match && out_free, r_state == S_IDLE && r_rsp_valid)

endmodule

### hw/rtl/sorted_list_insert_delete_search.sv
// Sorted key table top: insert and search answer at the accept edge, one per cycle while the response register is free.
// Delete steps: accept, one cell shift for each removed entry, then the result load.
// List accepts, then reads out one stored entry per cycle while the response register is free.
// Each result appears in the cycle after its last step, through the response register.
// Reset (i_rst_n, synchronous, active low) clears the count, FSM and response valid;
// key cells are not cleared, since entries at or above the count are never read.
module sorted_list_insert_delete_search
    import slids_pkg::*;
#(
    parameter int CAPACITY = SLIDS_CAPACITY
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    // request channel
    input  logic   i_req_valid,
    output logic   o_req_ready,
    input  t_req_s i_req,
    // response channel
    output logic   o_rsp_valid,
    input  logic   i_rsp_ready,
    output t_rsp_s o_rsp
);

    // controller/datapath handshake: commands down, table status up
    t_dp_cmd_s                   dp_cmd;
    t_dp_sts_s                   dp_sts;
    logic [$clog2(CAPACITY)-1:0] list_idx;

    // Controller: decides per request whether it completes in the accept
    // cycle (insert, search, any request on an empty table) or runs a
    // multi-cycle sequence (delete loop, list walk). It owns the response
    // valid flag and only loads the response register when it is free.
    slids_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_action    (i_req.action),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_list_idx  (list_idx)
    );

    // Datapath: a row of key cells, each comparing against the key in
    // parallel. Insert shifts the upper part up in a single update; delete pulls
    // the suffix down by one per step while any cell still matches.
    slids_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (i_req.key),
        .i_cmd      (dp_cmd),
        .i_list_idx (list_idx),
        .o_sts      (dp_sts),
        .o_rsp      (o_rsp)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for the sorted key table: directed and random requests, scoreboarded.
module testbench
    import slids_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits: the slowest legal run is far below this.
    localparam int MAX_CYCLES   = 200000;
    localparam int RANDOM_REQS  = 155;
    localparam int IDLE_PERCENT = 23;
    localparam int TAIL_CYCLES  = 40;   // a full list plus the output register, with margin

    // Keys that hit the signed extremes, zero, and the Q16.16 unit values.
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ZERO    = 32'sh0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_NEG_LSB = 32'shFFFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_POS_LSB = 32'sh0000_0001;
    localparam logic signed [KEY_W-1:0] KEY_ONE     = 32'sh0001_0000;
    localparam logic signed [KEY_W-1:0] KEY_NEG_ONE = 32'shFFFF_0000;
    localparam logic signed [KEY_W-1:0] KEY_HALF    = 32'sh0000_8000;

    // Shadow copy of the key table; predicts every response a request causes.
    class key_table_scoreboard;
        logic signed [KEY_W-1:0] keys [SLIDS_CAPACITY];
        int unsigned             count;
        t_rsp_s                  expected_q [$];
        int unsigned             act_seen [4];
        int unsigned             full_refusals;
        int unsigned             empty_errors;
        int unsigned             responses;
        int unsigned             mismatches;

        function t_rsp_s make_rsp(t_status st, logic fnd, int rem, int cnt,
                                  logic signed [KEY_W-1:0] val, logic lst);
            t_rsp_s rsp;
            rsp.status        = st;
            rsp.found         = fnd;
            rsp.removed_count = CNT_OUT_W'(rem);
            rsp.entry_count   = CNT_OUT_W'(cnt);
            rsp.item_value    = val;
            rsp.last          = lst;
            return rsp;
        endfunction

        // Called on every accepted request, in acceptance order.
        function void note_request(t_req_s req);
            int  pos;
            int  kept;
            int  hits;
            act_seen[int'(req.action)]++;
            if (req.action == ACT_INSERT) begin
                if (count >= SLIDS_CAPACITY) begin
                    full_refusals++;
                    expected_q.push_back(make_rsp(STAT_FULL, 1'b0, 0, count, '0, 1'b1));
                end else begin
                    // new key goes after every key less than or equal to it
                    pos = 0;
                    while (pos < count && $signed(keys[pos]) <= $signed(req.key))
                        pos++;
                    for (int j = count; j > pos; j--)
                        keys[j] = keys[j-1];
                    keys[pos] = req.key;
                    count++;
                    expected_q.push_back(make_rsp(STAT_OK, 1'b0, 0, count, '0, 1'b1));
                end
            end else if (count == 0) begin
                empty_errors++;
                expected_q.push_back(make_rsp(STAT_EMPTY, 1'b0, 0, 0, '0, 1'b1));
            end else begin
                case (req.action)
                    ACT_DELETE: begin
                        kept = 0;
                        hits = 0;
                        for (int i = 0; i < count; i++) begin
                            if (keys[i] == req.key) begin
                                hits++;
                            end else begin
                                keys[kept] = keys[i];
                                kept++;
                            end
                        end
                        count = kept;
                        expected_q.push_back(make_rsp(STAT_OK, 1'b0, hits, count, '0, 1'b1));
                    end
                    ACT_SEARCH: begin
                        hits = 0;
                        for (int i = 0; i < count; i++)
                            if (keys[i] == req.key)
                                hits = 1;
                        expected_q.push_back(make_rsp(STAT_OK, hits != 0, 0, count, '0, 1'b1));
                    end
                    default: begin
                        for (int i = 0; i < count; i++)
                            expected_q.push_back(make_rsp(STAT_OK, 1'b0, 0, count, keys[i],
                                                          i == count - 1));
                    end
                endcase
            end
        endfunction

        function void compare_field(string name, logic [KEY_W-1:0] exp_v,
                                    logic [KEY_W-1:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        // Called on every accepted response.
        function void check_response(t_rsp_s got);
            t_rsp_s exp_r;
            responses++;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: response with nothing expected, expected none, actual %0h",
                         $time, got);
            end else begin
                exp_r = expected_q.pop_front();
                compare_field("status", KEY_W'(exp_r.status), KEY_W'(got.status));
                compare_field("found", KEY_W'(exp_r.found), KEY_W'(got.found));
                compare_field("removed_count", KEY_W'(exp_r.removed_count),
                              KEY_W'(got.removed_count));
                compare_field("entry_count", KEY_W'(exp_r.entry_count),
                              KEY_W'(got.entry_count));
                compare_field("item_value", exp_r.item_value, got.item_value);
                compare_field("last", KEY_W'(exp_r.last), KEY_W'(got.last));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_req_valid = 1'b0;
    logic   o_req_ready;
    t_req_s i_req       = '0;
    logic   o_rsp_valid;
    logic   i_rsp_ready = 1'b0;
    t_rsp_s o_rsp;

    // Set during the burst with no idling on either side.
    logic   no_idle = 1'b0;
    int     cycles  = 0;

    key_table_scoreboard sb;

    sorted_list_insert_delete_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Response side: random back-pressure, except in the no-idle burst and during reset.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle)
            i_rsp_ready <= 1'b1;
        else
            i_rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Response monitor. Values are read at the edge, before this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            sb.check_response(o_rsp);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
            $display("testbench failed");
            $finish;
        end
    end

    // Present one request and hold it until accepted. Valid stays high into the
    // next request when no idle gap follows, so it is never dropped and raised
    // in the same time step.
    task automatic send_req(input t_action act, input logic signed [KEY_W-1:0] key);
        t_req_s req;
        int     gap;
        req.action  = act;
        req.key     = key;
        i_req       <= req;
        i_req_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_req_ready);
        sb.note_request(req);
        gap = 0;
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off new requests until every predicted response has come back.
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly keys from a small pool so that duplicates, hits and deletes happen;
    // the rest are fully random to toggle every key bit.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] pool [8];
        pool = '{KEY_MIN, KEY_MAX, KEY_ZERO, KEY_NEG_LSB,
                 KEY_POS_LSB, KEY_ONE, KEY_NEG_ONE, KEY_HALF};
        if ($urandom_range(99) < 65)
            return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Bias toward insert while the table is nearly empty so that the random
    // part spends its time on a populated table, and reaches full often.
    function automatic t_action pick_action();
        int roll;
        roll = $urandom_range(99);
        if (sb.count < 4)
            return (roll < 60) ? ACT_INSERT : (roll < 75) ? ACT_DELETE :
                   (roll < 90) ? ACT_SEARCH : ACT_LIST;
        return (roll < 40) ? ACT_INSERT : (roll < 60) ? ACT_DELETE :
               (roll < 84) ? ACT_SEARCH : ACT_LIST;
    endfunction

    initial begin
        sb = new;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: delete, search and list all report the empty error.
        send_req(ACT_LIST,   KEY_ZERO);
        send_req(ACT_DELETE, KEY_ZERO);
        send_req(ACT_SEARCH, KEY_MIN);

        // Extremes and a duplicate; equal keys land after the existing one.
        send_req(ACT_INSERT, KEY_MAX);
        send_req(ACT_INSERT, KEY_MIN);
        send_req(ACT_INSERT, KEY_ZERO);
        send_req(ACT_INSERT, KEY_NEG_LSB);
        send_req(ACT_INSERT, KEY_ZERO);
        send_req(ACT_SEARCH, KEY_ZERO);      // hit
        send_req(ACT_SEARCH, KEY_POS_LSB);   // miss
        send_req(ACT_DELETE, KEY_ONE);       // absent key, nothing removed
        send_req(ACT_LIST,   KEY_ZERO);

        // Fill to capacity with copies of the maximum, then one refused insert.
        for (int i = 0; i < SLIDS_CAPACITY - 5; i++)
            send_req(ACT_INSERT, KEY_MAX);
        send_req(ACT_INSERT, KEY_MIN);
        send_req(ACT_LIST,   KEY_ZERO);
        send_req(ACT_DELETE, KEY_MAX);       // many removed at once

        // Random traffic, with one full drain midway and a no-idle burst.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2)
                drain_responses();
            no_idle <= (n >= 100 && n < 140);
            send_req(pick_action(), pick_key());
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts, %0d deletes, %0d searches, %0d lists; %0d responses",
                 sb.act_seen[ACT_INSERT], sb.act_seen[ACT_DELETE],
                 sb.act_seen[ACT_SEARCH], sb.act_seen[ACT_LIST], sb.responses);
        $display("%0d full refusals, %0d empty errors, %0d mismatches, %0d outstanding",
                 sb.full_refusals, sb.empty_errors, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
